### rtl/smd_pkg.sv
// Shared types and constants for the SHA-1 message digest block.
package smd_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned PTR_W       = 4;
    localparam int unsigned ROUNDS      = 80;
    localparam int unsigned ROUND_W     = 7;
    localparam int unsigned MSG_W       = 61;
    localparam int unsigned DIGEST_N    = 5;
    localparam int unsigned IDX_W       = 3;
    localparam int unsigned COUNT_W     = 3;

    localparam logic [IDX_W-1:0]   LAST_INDEX = IDX_W'(DIGEST_N - 1);
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(4);

    localparam logic [WORD_W-1:0] H_INIT [DIGEST_N] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [WORD_W-1:0] K_0 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K_2 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [WORD_W-1:0] PAD_WORD = {PAD_BYTE, 24'h000000};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_OUT
    } smd_state_t;

endpackage

### rtl/sha1_message_digest.sv
// SHA-1 message digest: word collection, padding, iterative compression, digest output.
// A non-last transaction is accepted only while idle; every 16th word starts a compression
// (80 rounds through one shared round adder, one chaining add), during which input is held off.
// A last transaction adds padding words (one per cycle) and one or two compressions,
// then five digest transactions, one per cycle while m_ready is high.
// aresetn is synchronous, active low; it restores the initial chaining values.
module sha1_message_digest
    import smd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [WORD_W-1:0]   s_data_word,
    input  logic [COUNT_W-1:0]  s_byte_count,
    input  logic                s_last_item,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [WORD_W-1:0]   m_digest_word,
    output logic [IDX_W-1:0]    m_word_index,
    output logic                m_last_word
);

    smd_state_t state_reg, state_next;

    logic [WORD_W-1:0]  chain_reg [DIGEST_N];
    logic [WORD_W-1:0]  chain_next [DIGEST_N];
    logic [WORD_W-1:0]  sched_reg [BLOCK_WORDS];
    logic [WORD_W-1:0]  sched_next [BLOCK_WORDS];
    logic [WORD_W-1:0]  wa_reg, wb_reg, wc_reg, wd_reg, we_reg;
    logic [WORD_W-1:0]  wa_next, wb_next, wc_next, wd_next, we_next;
    logic [MSG_W-1:0]   msg_reg, msg_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [IDX_W-1:0]   oidx_reg, oidx_next;
    logic               pad_mode_reg, pad_mode_next;
    logic               marker_reg, marker_next;
    logic               len_hi_reg, len_hi_next;
    logic               final_reg, final_next;

    logic               in_fire;
    logic               out_fire;
    logic               shift_en;
    logic [WORD_W-1:0]  shift_word;
    logic [COUNT_W-1:0] count_sat;
    logic [WORD_W-1:0]  last_word_val;
    logic [63:0]        bit_len;
    logic [WORD_W-1:0]  pad_word;
    logic               pad_is_lo;
    logic               last_round;
    logic [WORD_W-1:0]  f_val, k_val, t_val, w_new;

    assign in_fire    = s_valid && s_ready;
    assign out_fire   = m_valid && m_ready;
    assign last_round = (round_reg == ROUND_W'(ROUNDS - 1));
    assign bit_len    = {msg_reg, 3'b000};

    // Saturate the byte count and build the final data word, with its marker byte if under four bytes
    always_comb begin
        count_sat = (s_byte_count > FULL_COUNT) ? FULL_COUNT : s_byte_count;
        case (count_sat)
            3'd0:    last_word_val = PAD_WORD;
            3'd1:    last_word_val = {s_data_word[31:24], PAD_BYTE, 16'h0000};
            3'd2:    last_word_val = {s_data_word[31:16], PAD_BYTE, 8'h00};
            3'd3:    last_word_val = {s_data_word[31:8], PAD_BYTE};
            default: last_word_val = s_data_word;
        endcase
    end

    // Select the next padding word: marker, zero, or the two length halves
    always_comb begin
        pad_is_lo = 1'b0;
        if (marker_reg) begin
            pad_word = PAD_WORD;
        end else if (wptr_reg == PTR_W'(BLOCK_WORDS - 2)) begin
            pad_word = bit_len[63:32];
        end else if (wptr_reg == PTR_W'(BLOCK_WORDS - 1) && len_hi_reg) begin
            pad_word  = bit_len[31:0];
            pad_is_lo = 1'b1;
        end else begin
            pad_word = '0;
        end
    end

    // Round function, constant and the shared round adder
    always_comb begin
        if (round_reg < ROUND_W'(20)) begin
            f_val = (wb_reg & wc_reg) | (~wb_reg & wd_reg);
            k_val = K_0;
        end else if (round_reg < ROUND_W'(40)) begin
            f_val = wb_reg ^ wc_reg ^ wd_reg;
            k_val = K_1;
        end else if (round_reg < ROUND_W'(60)) begin
            f_val = (wb_reg & wc_reg) | (wb_reg & wd_reg) | (wc_reg & wd_reg);
            k_val = K_2;
        end else begin
            f_val = wb_reg ^ wc_reg ^ wd_reg;
            k_val = K_3;
        end
        t_val = {wa_reg[26:0], wa_reg[31:27]} + f_val + we_reg + k_val + sched_reg[0];
        w_new = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
        w_new = {w_new[30:0], w_new[31]};
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (wptr_reg == PTR_W'(BLOCK_WORDS - 1)) begin
                        state_next = ST_ROUND;
                    end else if (s_last_item) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (wptr_reg == PTR_W'(BLOCK_WORDS - 1)) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (last_round) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                if (final_reg) begin
                    state_next = ST_OUT;
                end else if (pad_mode_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_fire && oidx_reg == LAST_INDEX) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs and digest word drive
    always_comb begin
        s_ready       = (state_reg == ST_IDLE);
        m_valid       = (state_reg == ST_OUT);
        m_digest_word = chain_reg[oidx_reg];
        m_word_index  = oidx_reg;
        m_last_word   = (oidx_reg == LAST_INDEX);
    end

    // Datapath next values
    always_comb begin
        chain_next    = chain_reg;
        wa_next       = wa_reg;
        wb_next       = wb_reg;
        wc_next       = wc_reg;
        wd_next       = wd_reg;
        we_next       = we_reg;
        msg_next      = msg_reg;
        round_next    = round_reg;
        wptr_next     = wptr_reg;
        oidx_next     = oidx_reg;
        pad_mode_next = pad_mode_reg;
        marker_next   = marker_reg;
        len_hi_next   = len_hi_reg;
        final_next    = final_reg;
        shift_en      = 1'b0;
        shift_word    = pad_word;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    shift_en  = 1'b1;
                    wptr_next = wptr_reg + PTR_W'(1);
                    if (s_last_item) begin
                        shift_word    = last_word_val;
                        msg_next      = msg_reg + MSG_W'(count_sat);
                        pad_mode_next = 1'b1;
                        marker_next   = (count_sat == FULL_COUNT);
                        len_hi_next   = 1'b0;
                        final_next    = 1'b0;
                    end else begin
                        shift_word = s_data_word;
                        msg_next   = msg_reg + MSG_W'(4);
                    end
                end
            end
            ST_PAD: begin
                shift_en    = 1'b1;
                wptr_next   = wptr_reg + PTR_W'(1);
                marker_next = 1'b0;
                if (!marker_reg && wptr_reg == PTR_W'(BLOCK_WORDS - 2)) begin
                    len_hi_next = 1'b1;
                end
                if (pad_is_lo) begin
                    final_next = 1'b1;
                end
            end
            ST_ROUND: begin
                shift_en   = 1'b1;
                shift_word = w_new;
                wa_next    = t_val;
                wb_next    = wa_reg;
                wc_next    = {wb_reg[1:0], wb_reg[31:2]};
                wd_next    = wc_reg;
                we_next    = wd_reg;
                round_next = last_round ? '0 : round_reg + ROUND_W'(1);
            end
            ST_ADD: begin
                chain_next[0] = chain_reg[0] + wa_reg;
                chain_next[1] = chain_reg[1] + wb_reg;
                chain_next[2] = chain_reg[2] + wc_reg;
                chain_next[3] = chain_reg[3] + wd_reg;
                chain_next[4] = chain_reg[4] + we_reg;
                oidx_next     = '0;
            end
            ST_OUT: begin
                if (out_fire) begin
                    if (oidx_reg == LAST_INDEX) begin
                        chain_next    = H_INIT;
                        msg_next      = '0;
                        wptr_next     = '0;
                        oidx_next     = '0;
                        pad_mode_next = 1'b0;
                        final_next    = 1'b0;
                        len_hi_next   = 1'b0;
                    end else begin
                        oidx_next = oidx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                final_next = 1'b0;
            end
        endcase

        // Load working variables from the chaining value when a block starts
        if (state_next == ST_ROUND && state_reg != ST_ROUND) begin
            wa_next = chain_next[0];
            wb_next = chain_next[1];
            wc_next = chain_next[2];
            wd_next = chain_next[3];
            we_next = chain_next[4];
        end

        // Advance the schedule shift line
        for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
            sched_next[i] = shift_en ? sched_reg[i+1] : sched_reg[i];
        end
        sched_next[BLOCK_WORDS-1] = shift_en ? shift_word : sched_reg[BLOCK_WORDS-1];
    end

    // Control state and chaining value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            chain_reg    <= H_INIT;
            msg_reg      <= '0;
            round_reg    <= '0;
            wptr_reg     <= '0;
            oidx_reg     <= '0;
            pad_mode_reg <= 1'b0;
            marker_reg   <= 1'b0;
            len_hi_reg   <= 1'b0;
            final_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            chain_reg    <= chain_next;
            msg_reg      <= msg_next;
            round_reg    <= round_next;
            wptr_reg     <= wptr_next;
            oidx_reg     <= oidx_next;
            pad_mode_reg <= pad_mode_next;
            marker_reg   <= marker_next;
            len_hi_reg   <= len_hi_next;
            final_reg    <= final_next;
        end
    end

    // Schedule and working variables
    always_ff @(posedge aclk) begin
        sched_reg <= sched_next;
        wa_reg    <= wa_next;
        wb_reg    <= wb_next;
        wc_reg    <= wc_next;
        wd_reg    <= wd_next;
        we_reg    <= we_next;
    end

endmodule

### rtl/smd_checker.sv
// Port-level checker for the SHA-1 message digest block, with its bind.
module smd_checker
    import smd_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               s_last_item,
    input logic               m_valid,
    input logic               m_ready,
    input logic [WORD_W-1:0]  m_digest_word,
    input logic [IDX_W-1:0]   m_word_index,
    input logic               m_last_word
);

    // Hold a stalled digest transaction
    property p_out_hold;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_digest_word) && $stable(m_word_index);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("digest transaction changed while stalled");

    // Never take input while the digest is being delivered
    property p_no_overlap;
        @(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid);
    endproperty
    a_no_overlap: assert property (p_no_overlap) else $error("input ready during digest output");

    // Digest words follow back to back in index order
    property p_index_step;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_word |=>
            m_valid && m_word_index == $past(m_word_index) + IDX_W'(1);
    endproperty
    a_index_step: assert property (p_index_step) else $error("digest word index out of order");

    // Last-word flag marks the fifth word only
    property p_last_flag;
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_last_word == (m_word_index == LAST_INDEX);
    endproperty
    a_last_flag: assert property (p_last_flag) else $error("last-word flag mismatch");

    // Padding and compression always separate the last input from the digest
    property p_last_gap;
        @(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_item |=> !m_valid;
    endproperty
    a_last_gap: assert property (p_last_gap) else $error("digest appeared without compression");

endmodule

bind sha1_message_digest smd_checker u_smd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_last_item   (s_last_item),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_digest_word (m_digest_word),
    .m_word_index  (m_word_index),
    .m_last_word   (m_last_word)
);

### tb/tb_sha1_message_digest.sv
// Self-checking testbench for the SHA-1 message digest block with a built-in digest predictor.
module tb_sha1_message_digest;
    import smd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One message word on the input channel, with the idle cycles placed before it
    typedef struct {
        logic [WORD_W-1:0]  data;
        logic [COUNT_W-1:0] count;
        logic               last;
        int unsigned        gap;
        bit                 drain;
    } msg_word_t;

    // One digest word as it should leave the result channel
    typedef struct {
        logic [WORD_W-1:0] word;
        logic [IDX_W-1:0]  index;
        logic              last;
    } digest_word_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [WORD_W-1:0]   s_data_word = '0;
    logic [COUNT_W-1:0]  s_byte_count = '0;
    logic                s_last_item = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [WORD_W-1:0]   m_digest_word;
    logic [IDX_W-1:0]    m_word_index;
    logic                m_last_word;

    msg_word_t    msg_word_q [$];
    digest_word_t digest_q [$];
    msg_word_t    cur_word;
    int unsigned  err_cnt = 0;

    // Predictor state: chaining values, block buffer, running byte count
    logic [WORD_W-1:0] chain_h [DIGEST_N];
    logic [WORD_W-1:0] blk_w [BLOCK_WORDS];
    logic [MSG_W-1:0]  msg_bytes;

    // Driver and receiver bookkeeping
    logic        tx_valid_nxt;
    int unsigned tx_idle;
    bit          tx_burst = 1'b0;
    logic        rx_ready_nxt;
    int unsigned rx_stall;
    bit          rx_burst = 1'b0;

    sha1_message_digest dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_word   (s_data_word),
        .s_byte_count  (s_byte_count),
        .s_last_item   (s_last_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last_word   (m_last_word)
    );

    // Clock and reset
    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Run the 80-round compression over the buffered block
    function automatic void sha1_compress();
        logic [WORD_W-1:0] sched [ROUNDS];
        logic [WORD_W-1:0] a, b, c, d, e, f, k, t, x;
        for (int j = 0; j < 16; j++) sched[j] = blk_w[j];
        for (int j = 16; j < ROUNDS; j++) begin
            x = sched[j-3] ^ sched[j-8] ^ sched[j-14] ^ sched[j-16];
            sched[j] = {x[30:0], x[31]};
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int j = 0; j < ROUNDS; j++) begin
            if (j < 20) begin
                f = (b & c) | (~b & d);
                k = K_0;
            end else if (j < 40) begin
                f = b ^ c ^ d;
                k = K_1;
            end else if (j < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_2;
            end else begin
                f = b ^ c ^ d;
                k = K_3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + sched[j];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    // Store a word in the block buffer; compress once the block is full
    function automatic logic [PTR_W-1:0] load_block_word(logic [PTR_W-1:0] slot,
                                                          logic [WORD_W-1:0] w);
        blk_w[slot] = w;
        slot = slot + 1'b1;
        if (slot == '0) sha1_compress();
        return slot;
    endfunction

    // Advance the predicted hash state; on a last word queue the five digest words
    task automatic predict_digest(msg_word_t it);
        logic [PTR_W-1:0]   slot;
        logic [COUNT_W-1:0] cnt;
        logic [63:0]        bit_len;
        digest_word_t       dw;
        slot = msg_bytes[5:2];
        if (!it.last) begin
            msg_bytes = msg_bytes + MSG_W'(4);
            void'(load_block_word(slot, it.data));
            return;
        end
        cnt = (it.count > FULL_COUNT) ? FULL_COUNT : it.count;
        msg_bytes = msg_bytes + MSG_W'(cnt);
        bit_len = {msg_bytes, 3'b000};
        // Append the pad byte right after the valid bytes
        case (cnt)
            3'd0: slot = load_block_word(slot, PAD_WORD);
            3'd1: slot = load_block_word(slot, {it.data[31:24], PAD_BYTE, 16'h0000});
            3'd2: slot = load_block_word(slot, {it.data[31:16], PAD_BYTE, 8'h00});
            3'd3: slot = load_block_word(slot, {it.data[31:8], PAD_BYTE});
            default: begin
                slot = load_block_word(slot, it.data);
                slot = load_block_word(slot, PAD_WORD);
            end
        endcase
        while (slot != 4'd14) slot = load_block_word(slot, '0);
        slot = load_block_word(slot, bit_len[63:32]);
        void'(load_block_word(slot, bit_len[31:0]));
        for (int i = 0; i < DIGEST_N; i++) begin
            dw.word  = chain_h[i];
            dw.index = IDX_W'(i);
            dw.last  = (dw.index == LAST_INDEX);
            digest_q = {digest_q, dw};
        end
        chain_h   = H_INIT;
        msg_bytes = '0;
    endtask

    task automatic report_mismatch(string msg);
        $display("%0t ns mismatch: %s", $realtime, msg);
        err_cnt++;
    endtask

    // Compare one received digest word with the oldest prediction
    task automatic check_digest_word();
        digest_word_t exp_w;
        if (digest_q.size() == 0) begin
            report_mismatch($sformatf("unexpected digest word %08h index %0d",
                                      m_digest_word, m_word_index));
            return;
        end
        exp_w = digest_q.pop_front();
        if (m_digest_word !== exp_w.word)
            report_mismatch($sformatf("digest word %0d: got %08h, want %08h",
                                      exp_w.index, m_digest_word, exp_w.word));
        if (m_word_index !== exp_w.index)
            report_mismatch($sformatf("word index: got %0d, want %0d",
                                      m_word_index, exp_w.index));
        if (m_last_word !== exp_w.last)
            report_mismatch($sformatf("last word flag at index %0d: got %b, want %b",
                                      exp_w.index, m_last_word, exp_w.last));
    endtask

    // Driver: present queued words, predict on each accepted transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_idle = 0;
        end else begin
            tx_valid_nxt = s_valid;
            if (s_valid && s_ready) begin
                predict_digest(cur_word);
                tx_valid_nxt = 1'b0;
            end
            if (!tx_valid_nxt && msg_word_q.size() != 0) begin
                // Hold a draining word back until all digests are out
                if (!(msg_word_q[0].drain && digest_q.size() != 0)) begin
                    if (tx_idle < msg_word_q[0].gap) begin
                        tx_idle++;
                    end else begin
                        cur_word = msg_word_q.pop_front();
                        s_data_word  <= cur_word.data;
                        s_byte_count <= cur_word.count;
                        s_last_item  <= cur_word.last;
                        tx_valid_nxt = 1'b1;
                        tx_idle = 0;
                    end
                end
            end
            s_valid <= tx_valid_nxt;
        end
    end

    // Monitor: check each accepted digest transaction, stall at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_stall = 0;
        end else begin
            rx_ready_nxt = m_ready;
            if (m_valid && m_ready) begin
                check_digest_word();
                rx_ready_nxt = 1'b0;
                if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
                rx_stall = rx_burst ? 0 : $urandom_range(0, 11);
            end
            if (!rx_ready_nxt) begin
                if (rx_stall != 0) rx_stall--;
                else rx_ready_nxt = 1'b1;
            end
            m_ready <= rx_ready_nxt;
        end
    end

    task automatic add_word(logic [WORD_W-1:0] data, logic [COUNT_W-1:0] count,
                            logic last, bit drain);
        msg_word_t it;
        it.data  = data;
        it.count = count;
        it.last  = last;
        it.gap   = tx_burst ? 0 : $urandom_range(0, 11);
        it.drain = drain;
        msg_word_q = {msg_word_q, it};
    endtask

    function automatic logic [WORD_W-1:0] rand_data();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Stimulus: directed messages, random messages, then drain and report
    initial begin
        int unsigned n_words;
        int unsigned rand_items;
        logic [COUNT_W-1:0] last_cnt;
        bit drain;

        chain_h   = H_INIT;
        msg_bytes = '0;

        // Empty message
        add_word('0, 3'd0, 1'b1, 1'b0);
        // "abc" with a junk byte past the count
        add_word(32'h616263FF, 3'd3, 1'b1, 1'b0);
        add_word('1, 3'd1, 1'b1, 1'b0);
        add_word(32'hA5C3FFFF, 3'd2, 1'b1, 1'b0);
        add_word('1, FULL_COUNT, 1'b1, 1'b0);
        // Oversized counts on the last word saturate to four
        add_word($urandom, 3'd5, 1'b1, 1'b0);
        add_word($urandom, 3'd7, 1'b1, 1'b0);
        // Thirteen words plus a full last word: padding spills into a second block,
        // counts on non-last words are ignored
        add_word('0, 3'd0, 1'b0, 1'b1);
        add_word('1, 3'd7, 1'b0, 1'b0);
        for (int i = 0; i < 11; i++)
            add_word($urandom, (i % 3 == 0) ? COUNT_W'($urandom_range(0, 7)) : FULL_COUNT,
                     1'b0, 1'b0);
        add_word($urandom, FULL_COUNT, 1'b1, 1'b0);

        // Random messages, mostly short, some across block boundaries
        rand_items = 0;
        drain = 1'b1;
        while (rand_items < 200) begin
            if ($urandom_range(0, 3) == 0) tx_burst = !tx_burst;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: n_words = $urandom_range(0, 16);
                6, 7, 8:          n_words = $urandom_range(13, 20);
                default:          n_words = $urandom_range(20, 47);
            endcase
            if ($urandom_range(0, 9) < 8) last_cnt = COUNT_W'($urandom_range(0, 4));
            else last_cnt = COUNT_W'($urandom_range(5, 7));
            for (int i = 0; i < n_words; i++) begin
                add_word(rand_data(),
                         ($urandom_range(0, 7) == 0) ? COUNT_W'($urandom_range(0, 7))
                                                     : FULL_COUNT,
                         1'b0, drain && i == 0);
            end
            add_word(rand_data(), last_cnt, 1'b1, drain && n_words == 0);
            rand_items += n_words + 1;
            drain = ($urandom_range(0, 9) == 0);
        end

        // Wait for the input queue and the predicted digests to empty
        while (msg_word_q.size() != 0 || s_valid) @(negedge aclk);
        while (digest_q.size() != 0) @(negedge aclk);
        repeat (200) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("[sha1_message_digest] OK");
        end else begin
            $display("[sha1_message_digest] ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("[sha1_message_digest] ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/smd_pkg.sv
rtl/sha1_message_digest.sv
rtl/smd_checker.sv
tb/tb_sha1_message_digest.sv
